### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helper macro for the tracked object table.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

### src/tote_pkg.sv
// ---------------------------------------------------------------------------
// Tracked object table package
// Field layout, register indexes, codes and control types.
// ---------------------------------------------------------------------------
package tote_pkg;

  localparam int IN_DATA_W  = 144;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int IN_MMSI_LO  = 0;
  localparam int IN_LAT_LO   = 30;
  localparam int IN_LON_LO   = 58;
  localparam int IN_HSTAT_LO = 87;
  localparam int IN_LEN_LO   = 88;
  localparam int IN_TYPE_LO  = 98;
  localparam int IN_NOW_LO   = 106;

  localparam logic [1:0] KIND_POS    = 2'd0;
  localparam logic [1:0] KIND_STATIC = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_CENTRE_LAT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTRE_LON = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LON_SCALE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LAT_SCALE  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TTL_MS     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_LEN    = 3'd5;

  localparam logic [7:0] TYPE_SAIL     = 8'd36;
  localparam logic [7:0] TYPE_PLEASURE = 8'd37;

  typedef struct packed {
    logic       latch;
    logic       scan_clr;
    logic       scan;
    logic       ev;
    logic [1:0] ev_ph;
    logic       ev_first;
    logic       place;
    logic       commit;
    logic       sweep;
    logic       sweep_end;
    logic       resp;
  } dp_cmd_t;

  typedef struct packed {
    logic is_stat;
    logic is_sweep;
    logic skip;
    logic tbl_hit;
    logic full;
    logic k_in_live;
    logic out_busy;
  } dp_stat_t;

endpackage

### src/tote_ctrl.sv
// ---------------------------------------------------------------------------
// Tracked object table controller
// Sequences lookup, eviction, commit and expire sweep over the datapath.
// ---------------------------------------------------------------------------
module tote_ctrl import tote_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int CACHE_DEPTH = 32,
  parameter int KW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  dp_stat_t      stat,
  output dp_cmd_t       cmd,
  output logic [KW-1:0] scan_idx
);

  localparam int MAXD = (TABLE_DEPTH > CACHE_DEPTH) ? TABLE_DEPTH : CACHE_DEPTH;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_EVICT  = 4'd4;
  localparam logic [3:0] S_PLACE  = 4'd5;
  localparam logic [3:0] S_COMMIT = 4'd6;
  localparam logic [3:0] S_SWEEP  = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  logic [3:0]    state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [1:0]    ph_r, ph_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign scan_idx  = k_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    ph_nxt    = ph_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.scan_clr = 1'b1;
        k_nxt        = '0;
        if (stat.skip) begin
          state_nxt = S_RESP;
        end else if (stat.is_sweep) begin
          state_nxt = S_SWEEP;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (k_r == KW'(MAXD - 1)) begin
          state_nxt = S_DECIDE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DECIDE: begin
        k_nxt  = '0;
        ph_nxt = '0;
        if (stat.is_stat) begin
          state_nxt = S_COMMIT;
        end else if (stat.tbl_hit || !stat.full) begin
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        cmd.ev       = 1'b1;
        cmd.ev_ph    = ph_r;
        cmd.ev_first = (k_r == '0);
        ph_nxt       = ph_r + 1'b1;
        if (ph_r == 2'd3) begin
          if (k_r == KW'(TABLE_DEPTH - 1)) begin
            state_nxt = S_PLACE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_RESP;
      end
      S_SWEEP: begin
        if (stat.k_in_live) begin
          cmd.sweep = 1'b1;
          k_nxt     = k_r + 1'b1;
        end else begin
          cmd.sweep_end = 1'b1;
          state_nxt     = S_RESP;
        end
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd.resp  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      ph_r    <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      ph_r    <= ph_nxt;
    end
  end

endmodule

### src/tote_dpath.sv
// ---------------------------------------------------------------------------
// Tracked object table datapath
// Holds configuration, table, side cache, distance unit and result register.
// ---------------------------------------------------------------------------
module tote_dpath import tote_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int CACHE_DEPTH = 32,
  parameter int KW = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  dp_cmd_t               cmd,
  input  logic [KW-1:0]         scan_idx,
  output dp_stat_t              stat
);

  localparam int TW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(CACHE_DEPTH);
  localparam int LW = $clog2(TABLE_DEPTH + 1);

  logic signed [27:0] c_lat_r;
  logic signed [28:0] c_lon_r;
  logic [15:0]        lon_scale_r, lat_scale_r;
  logic [31:0]        ttl_r;
  logic [9:0]         min_len_r;

  logic [1:0]         it_kind;
  logic [29:0]        it_id;
  logic signed [27:0] it_lat;
  logic signed [28:0] it_lon;
  logic               it_hstat;
  logic [9:0]         it_len;
  logic [7:0]         it_type;
  logic [31:0]        it_now;

  logic [29:0]        entry_id_r   [TABLE_DEPTH];
  logic signed [27:0] entry_lat_r  [TABLE_DEPTH];
  logic signed [28:0] entry_lon_r  [TABLE_DEPTH];
  logic [9:0]         entry_len_r  [TABLE_DEPTH];
  logic [7:0]         entry_type_r [TABLE_DEPTH];
  logic [31:0]        entry_seen_r [TABLE_DEPTH];
  logic [29:0]        cache_id_r   [CACHE_DEPTH];
  logic [9:0]         cache_len_r  [CACHE_DEPTH];
  logic [7:0]         cache_type_r [CACHE_DEPTH];

  logic [LW-1:0] live_r, w_r;
  logic [CW-1:0] cnext_r, chit_idx_r;
  logic [TW-1:0] hit_idx_r, win_r, slot_r;
  logic          tbl_hit_r, c_hit_r, new_r, adm_r, evd_r;
  logic [9:0]    c_len_r;
  logic [7:0]    c_type_r;
  logic [29:0]   evid_r;
  logic [29:0]   adx_r, dx_r;
  logic [28:0]   ady_r, dy_r;
  logic [59:0]   sqx_r;
  logic [57:0]   sqy_r;
  logic          np_r, wnp_r;
  logic [60:0]   wd_r;
  logic          out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [TW-1:0] k_t, rd_idx, cm_idx;
  logic [CW-1:0] k_c;
  logic          is_pos, is_drop, k_in_tbl, k_in_cache;
  logic [29:0]        e_id;
  logic signed [27:0] e_lat;
  logic signed [28:0] e_lon;
  logic [9:0]         e_len;
  logic [7:0]         e_type;
  logic [31:0]        e_seen, age;
  logic signed [29:0] dlon;
  logic signed [28:0] dlat;
  logic [45:0]        px;
  logic [44:0]        py;
  logic [60:0]        dsum;
  logic               e_np, better;
  logic [9:0]  base_len, rec_len, fin_len, st_len, cw_len;
  logic [7:0]  base_type, rec_type, fin_type, st_type, cw_type;
  logic        twe, cwe, keep;
  logic [TW-1:0] twa;
  logic [CW-1:0] cwa;
  logic [29:0]        tw_id;
  logic signed [27:0] tw_lat;
  logic signed [28:0] tw_lon;
  logic [9:0]         tw_len;
  logic [7:0]         tw_type;
  logic [31:0]        tw_seen;

  assign k_t        = scan_idx[TW-1:0];
  assign k_c        = scan_idx[CW-1:0];
  assign k_in_tbl   = scan_idx < KW'(live_r);
  assign k_in_cache = scan_idx < KW'(CACHE_DEPTH);
  assign is_pos     = (it_kind == KIND_POS);
  assign is_drop    = ((it_kind == KIND_POS) || (it_kind == KIND_STATIC)) && (it_id == '0);
  assign cm_idx     = is_pos ? slot_r : hit_idx_r;

  always_comb begin
    if (cmd.place) begin
      rd_idx = win_r;
    end else if (cmd.commit) begin
      rd_idx = cm_idx;
    end else begin
      rd_idx = k_t;
    end
  end

  assign e_id   = entry_id_r[rd_idx];
  assign e_lat  = entry_lat_r[rd_idx];
  assign e_lon  = entry_lon_r[rd_idx];
  assign e_len  = entry_len_r[rd_idx];
  assign e_type = entry_type_r[rd_idx];
  assign e_seen = entry_seen_r[rd_idx];

  assign stat.is_stat   = (it_kind == KIND_STATIC);
  assign stat.is_sweep  = (it_kind == KIND_EXPIRE);
  assign stat.skip      = is_drop || (it_kind == KIND_NONE);
  assign stat.tbl_hit   = tbl_hit_r;
  assign stat.full      = (live_r == LW'(TABLE_DEPTH));
  assign stat.k_in_live = k_in_tbl;
  assign stat.out_busy  = out_valid_r && !out_tready;

  // Distance unit, one stage per eviction phase.
  assign dlon = 30'(e_lon) - 30'(c_lon_r);
  assign dlat = 29'(e_lat) - 29'(c_lat_r);
  assign px   = adx_r * lon_scale_r;
  assign py   = ady_r * lat_scale_r;
  assign dsum = 61'(sqx_r) + 61'(sqy_r);
  assign e_np = !((e_type == TYPE_SAIL) || (e_type == TYPE_PLEASURE) || (e_type == '0) ||
                  (e_len >= min_len_r));
  assign better = ((np_r && !wnp_r) || ((np_r == wnp_r) && (dsum > wd_r)));

  assign age  = it_now - e_seen;
  assign keep = age < ttl_r;

  always_comb begin
    base_len  = new_r ? '0 : e_len;
    base_type = new_r ? '0 : e_type;
    rec_len   = base_len;
    rec_type  = base_type;
    if (!((base_len != '0) && (base_type != '0)) && c_hit_r) begin
      rec_len  = (base_len != '0) ? base_len : c_len_r;
      rec_type = (base_type != '0) ? base_type : c_type_r;
    end
    fin_len  = (it_hstat && (it_len != '0)) ? it_len : rec_len;
    fin_type = (it_hstat && (it_type != '0)) ? it_type : rec_type;
    st_len   = (it_len != '0) ? it_len : e_len;
    st_type  = (it_type != '0) ? it_type : e_type;
  end

  always_comb begin
    twe     = 1'b0;
    twa     = cm_idx;
    tw_id   = e_id;
    tw_lat  = e_lat;
    tw_lon  = e_lon;
    tw_len  = e_len;
    tw_type = e_type;
    tw_seen = e_seen;
    if (cmd.commit && is_pos) begin
      twe     = 1'b1;
      tw_id   = it_id;
      tw_lat  = it_lat;
      tw_lon  = it_lon;
      tw_len  = fin_len;
      tw_type = fin_type;
      tw_seen = it_now;
    end else if (cmd.commit && tbl_hit_r) begin
      twe     = 1'b1;
      tw_len  = st_len;
      tw_type = st_type;
    end else if (cmd.sweep && keep) begin
      twe = 1'b1;
      twa = w_r[TW-1:0];
    end
  end

  assign cwe = cmd.commit && (!is_pos || it_hstat) && ((it_len != '0) || (it_type != '0));
  assign cwa = c_hit_r ? chit_idx_r : cnext_r;
  assign cw_len  = (c_hit_r && (it_len == '0)) ? c_len_r : it_len;
  assign cw_type = (c_hit_r && (it_type == '0)) ? c_type_r : it_type;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_lat_r     <= 28'sd43503000;
      c_lon_r     <= 29'sd7005000;
      lon_scale_r <= 16'd1588;
      lat_scale_r <= 16'd2174;
      ttl_r       <= 32'd300000;
      min_len_r   <= 10'd24;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CENTRE_LAT: c_lat_r     <= cfg_wdata[27:0];
        REG_CENTRE_LON: c_lon_r     <= cfg_wdata[28:0];
        REG_LON_SCALE:  lon_scale_r <= cfg_wdata[15:0];
        REG_LAT_SCALE:  lat_scale_r <= cfg_wdata[15:0];
        REG_TTL_MS:     ttl_r       <= cfg_wdata;
        REG_MIN_LEN:    min_len_r   <= cfg_wdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_kind  <= in_tuser;
      it_id    <= in_tdata[IN_MMSI_LO +: 30];
      it_lat   <= in_tdata[IN_LAT_LO +: 28];
      it_lon   <= in_tdata[IN_LON_LO +: 29];
      it_hstat <= in_tdata[IN_HSTAT_LO];
      it_len   <= in_tdata[IN_LEN_LO +: 10];
      it_type  <= in_tdata[IN_TYPE_LO +: 8];
      it_now   <= in_tdata[IN_NOW_LO +: 32];
    end
    if (twe) begin
      entry_id_r[twa]   <= tw_id;
      entry_lat_r[twa]  <= tw_lat;
      entry_lon_r[twa]  <= tw_lon;
      entry_len_r[twa]  <= tw_len;
      entry_type_r[twa] <= tw_type;
      entry_seen_r[twa] <= tw_seen;
    end
    if (cwe) begin
      cache_len_r[cwa]  <= cw_len;
      cache_type_r[cwa] <= cw_type;
    end
    if (cmd.scan && k_in_cache && !c_hit_r && (cache_id_r[k_c] == it_id)) begin
      chit_idx_r <= k_c;
      c_len_r    <= cache_len_r[k_c];
      c_type_r   <= cache_type_r[k_c];
    end
    if (cmd.scan && k_in_tbl && !tbl_hit_r && (e_id == it_id)) begin
      hit_idx_r <= k_t;
    end
    if (cmd.ev) begin
      case (cmd.ev_ph)
        2'd0: begin
          adx_r <= dlon[29] ? 30'(-dlon) : 30'(dlon);
          ady_r <= dlat[28] ? 29'(-dlat) : 29'(dlat);
          np_r  <= e_np;
        end
        2'd1: begin
          dx_r <= px[45:16];
          dy_r <= py[44:16];
        end
        2'd2: begin
          sqx_r <= dx_r * dx_r;
          sqy_r <= dy_r * dy_r;
        end
        default: begin
          if (cmd.ev_first || better) begin
            win_r <= k_t;
            wnp_r <= np_r;
            wd_r  <= dsum;
          end
        end
      endcase
    end
    if (cmd.place) begin
      if (tbl_hit_r) begin
        slot_r <= hit_idx_r;
      end else if (!stat.full) begin
        slot_r <= live_r[TW-1:0];
      end else begin
        slot_r <= win_r;
        evid_r <= e_id;
      end
    end else if (cmd.latch) begin
      evid_r <= '0;
    end
    if (cmd.resp) begin
      out_data_r <= {6'd0, is_drop, 5'(live_r), evid_r, evd_r, adm_r,
                     (is_pos && !is_drop) ? 4'(slot_r) : 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        cache_id_r[i] <= '0;
      end
    end else if (cwe) begin
      cache_id_r[cwa] <= it_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      cnext_r     <= '0;
      w_r         <= '0;
      tbl_hit_r   <= 1'b0;
      c_hit_r     <= 1'b0;
      new_r       <= 1'b0;
      adm_r       <= 1'b0;
      evd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.latch) begin
        adm_r <= 1'b0;
        evd_r <= 1'b0;
        new_r <= 1'b0;
      end
      if (cmd.scan_clr) begin
        tbl_hit_r <= 1'b0;
        c_hit_r   <= 1'b0;
        w_r       <= '0;
      end
      if (cmd.scan && k_in_cache && (cache_id_r[k_c] == it_id)) begin
        c_hit_r <= 1'b1;
      end
      if (cmd.scan && k_in_tbl && (e_id == it_id)) begin
        tbl_hit_r <= 1'b1;
      end
      if (cmd.place && !tbl_hit_r) begin
        new_r <= 1'b1;
        adm_r <= 1'b1;
        if (!stat.full) begin
          live_r <= live_r + 1'b1;
        end else begin
          evd_r <= 1'b1;
        end
      end
      if (cwe && !c_hit_r) begin
        cnext_r <= (cnext_r == CW'(CACHE_DEPTH - 1)) ? '0 : cnext_r + 1'b1;
      end
      if (cmd.sweep && keep) begin
        w_r <= w_r + 1'b1;
      end
      if (cmd.sweep_end) begin
        live_r <= w_r;
      end
      if (cmd.resp) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### src/tracked_object_table_evict_core.sv
// ---------------------------------------------------------------------------
// Tracked object table with eviction
// Identifier-keyed object table with a static-data side cache.
//
//   Channel  Direction  Handshake            Payload
//   in       slave      in_tvalid/in_tready  in_tdata, in_tuser (kind)
//   out      master     out_tvalid/out_tready out_tdata
//   cfg      slave      cfg_we               cfg_addr, cfg_wdata
//
// One item at a time. Static data and position reports scan the table and
// cache in full, a position report that evicts also runs every table entry
// through the distance unit phase by phase, and an expire sweep walks the
// live entries. Reset is synchronous and clears the cache identifiers. A
// result waits in the output register while the next beat is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tracked_object_table_evict_core import tote_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int CACHE_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // mmsi, lat, lon, has_static, obj_len, obj_type, now_ms, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // slot, admitted, evicted, evicted_mmsi, count, dropped, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int MAXD = (TABLE_DEPTH > CACHE_DEPTH) ? TABLE_DEPTH : CACHE_DEPTH;
  localparam int KW   = $clog2(MAXD + 1);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [KW-1:0] scan_idx;
  logic [6:0]    step_cmds;

  tote_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CACHE_DEPTH(CACHE_DEPTH),
    .KW(KW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .stat(stat),
    .cmd(cmd),
    .scan_idx(scan_idx)
  );

  tote_dpath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .CACHE_DEPTH(CACHE_DEPTH),
    .KW(KW)
  ) u_dpath (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .cmd(cmd),
    .scan_idx(scan_idx),
    .stat(stat)
  );

  assign step_cmds = {cmd.scan, cmd.ev, cmd.place, cmd.commit, cmd.sweep, cmd.sweep_end,
                      cmd.resp};

  `ASSERT_CLK(a_busy_after_beat, in_tvalid && in_tready |=> !in_tready, "ready after beat")
  `ASSERT_CLK(a_one_step, $onehot0(step_cmds), "overlapping steps")
  `ASSERT_CLK(a_result_source, $rose(out_tvalid) |-> $past(cmd.resp), "result without step")

endmodule

### sim/tote_checker.sv
// ---------------------------------------------------------------------------
// Tracked object table checker
// Watches the input and result channels of the tracked object table, keeps
// its own copy of the table, the static cache and the registers, predicts one
// result per accepted input beat and compares every result beat field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tote_checker import tote_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int CACHE_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic        dropped;
    logic [4:0]  count;
    logic [29:0] evicted_mmsi;
    logic        evicted;
    logic        admitted;
    logic [3:0]  slot;
  } track_result_t;

  logic signed [27:0] ref_lat;
  logic signed [28:0] ref_lon;
  logic [15:0] east_scale, north_scale;
  logic [31:0] age_limit;
  logic [9:0]  long_len;

  logic [29:0]        tbl_id   [TABLE_DEPTH];
  logic signed [27:0] tbl_lat  [TABLE_DEPTH];
  logic signed [28:0] tbl_lon  [TABLE_DEPTH];
  logic [9:0]         tbl_len  [TABLE_DEPTH];
  logic [7:0]         tbl_type [TABLE_DEPTH];
  logic [31:0]        tbl_seen [TABLE_DEPTH];
  int                 live;
  logic [29:0]        sc_id    [CACHE_DEPTH];
  logic [9:0]         sc_len   [CACHE_DEPTH];
  logic [7:0]         sc_type  [CACHE_DEPTH];
  int                 sc_next;

  track_result_t expected_results[$];

  function automatic logic [63:0] axis_dist(longint a, longint b, logic [15:0] scale);
    longint d;
    logic [63:0] m;
    d = a - b;
    m = (d < 0) ? -d : d;
    return (m * scale) >> 16;
  endfunction

  function automatic logic [63:0] range_sq(int i);
    logic [63:0] dx, dy;
    dx = axis_dist(tbl_lon[i], ref_lon, east_scale);
    dy = axis_dist(tbl_lat[i], ref_lat, north_scale);
    return dx * dx + dy * dy;
  endfunction

  function automatic bit is_preferred(int i);
    if (tbl_type[i] == TYPE_SAIL || tbl_type[i] == TYPE_PLEASURE || tbl_type[i] == 0)
      return 1;
    return tbl_len[i] >= long_len;
  endfunction

  function automatic int find_entry(logic [29:0] id);
    for (int i = 0; i < live; i++)
      if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  task automatic merge_static(logic [29:0] id, logic [9:0] len, logic [7:0] typ);
    int e;
    bit hit;
    hit = 0;
    if (len != 0 || typ != 0) begin
      for (int i = 0; i < CACHE_DEPTH && !hit; i++) begin
        if (sc_id[i] == id) begin
          if (len != 0) sc_len[i] = len;
          if (typ != 0) sc_type[i] = typ;
          hit = 1;
        end
      end
      if (!hit) begin
        sc_id[sc_next] = id;
        sc_len[sc_next] = len;
        sc_type[sc_next] = typ;
        sc_next = (sc_next + 1) % CACHE_DEPTH;
      end
    end
    e = find_entry(id);
    if (e >= 0) begin
      if (len != 0) tbl_len[e] = len;
      if (typ != 0) tbl_type[e] = typ;
    end
  endtask

  task automatic predict_track(logic [1:0] kind, logic [IN_DATA_W-1:0] d);
    track_result_t r;
    logic [29:0] id;
    logic [31:0] now;
    logic [9:0] len;
    logic [7:0] typ;
    int e, s, w;
    bit w_np, np, found;
    logic [63:0] w_d, dd;
    r = '0;
    id = d[IN_MMSI_LO +: 30];
    len = d[IN_LEN_LO +: 10];
    typ = d[IN_TYPE_LO +: 8];
    now = d[IN_NOW_LO +: 32];
    if ((kind == KIND_POS || kind == KIND_STATIC) && id == 0) begin
      r.dropped = 1;
    end else if (kind == KIND_POS) begin
      e = find_entry(id);
      if (e >= 0) begin
        s = e;
      end else begin
        if (live < TABLE_DEPTH) begin
          s = live;
          live++;
        end else begin
          s = 0;
          w_np = !is_preferred(0);
          w_d = range_sq(0);
          for (int i = 1; i < TABLE_DEPTH; i++) begin
            np = !is_preferred(i);
            dd = range_sq(i);
            if ((np && !w_np) || (np == w_np && dd > w_d)) begin
              s = i;
              w_np = np;
              w_d = dd;
            end
          end
          r.evicted = 1;
          r.evicted_mmsi = tbl_id[s];
        end
        r.admitted = 1;
        tbl_id[s] = id;
        tbl_len[s] = 0;
        tbl_type[s] = 0;
      end
      if (tbl_len[s] == 0 || tbl_type[s] == 0) begin
        found = 0;
        for (int i = 0; i < CACHE_DEPTH && !found; i++) begin
          if (sc_id[i] == tbl_id[s]) begin
            if (tbl_len[s] == 0) tbl_len[s] = sc_len[i];
            if (tbl_type[s] == 0) tbl_type[s] = sc_type[i];
            found = 1;
          end
        end
      end
      tbl_lat[s] = d[IN_LAT_LO +: 28];
      tbl_lon[s] = d[IN_LON_LO +: 29];
      if (d[IN_HSTAT_LO]) merge_static(id, len, typ);
      tbl_seen[s] = now;
      r.slot = s[3:0];
    end else if (kind == KIND_STATIC) begin
      merge_static(id, len, typ);
    end else if (kind == KIND_EXPIRE) begin
      w = 0;
      for (int i = 0; i < live; i++) begin
        if (32'(now - tbl_seen[i]) < age_limit) begin
          tbl_id[w] = tbl_id[i];
          tbl_lat[w] = tbl_lat[i];
          tbl_lon[w] = tbl_lon[i];
          tbl_len[w] = tbl_len[i];
          tbl_type[w] = tbl_type[i];
          tbl_seen[w] = tbl_seen[i];
          w++;
        end
      end
      live = w;
    end
    r.count = live[4:0];
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    track_result_t got, want;
    if (!rst_n) begin
      ref_lat <= 28'sd43503000;
      ref_lon <= 29'sd7005000;
      east_scale <= 16'd1588;
      north_scale <= 16'd2174;
      age_limit <= 32'd300000;
      long_len <= 10'd24;
      live = 0;
      sc_next = 0;
      for (int i = 0; i < CACHE_DEPTH; i++) begin
        sc_id[i] = '0;
        sc_len[i] = '0;
        sc_type[i] = '0;
      end
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_CENTRE_LAT: ref_lat <= cfg_wdata[27:0];
          REG_CENTRE_LON: ref_lon <= cfg_wdata[28:0];
          REG_LON_SCALE:  east_scale <= cfg_wdata[15:0];
          REG_LAT_SCALE:  north_scale <= cfg_wdata[15:0];
          REG_TTL_MS:     age_limit <= cfg_wdata;
          REG_MIN_LEN:    long_len <= cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_track(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got = out_tdata[41:0];
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
          if (got.admitted != want.admitted)
            report_mismatch("admitted", got.admitted, want.admitted);
          if (got.evicted != want.evicted)
            report_mismatch("evicted", got.evicted, want.evicted);
          if (got.evicted_mmsi != want.evicted_mmsi)
            report_mismatch("evicted_mmsi", got.evicted_mmsi, want.evicted_mmsi);
          if (got.count != want.count) report_mismatch("count", got.count, want.count);
          if (got.dropped != want.dropped)
            report_mismatch("dropped", got.dropped, want.dropped);
          if (out_tdata[47:42] != 0) report_mismatch("pad", out_tdata[47:42], 0);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

### sim/tb_tracked_object_table_evict_core.sv
// ---------------------------------------------------------------------------
// Tracked object table testbench
// Drives position, static, expire and unknown-kind beats in random bursts against the
// table core, stalls the result side, changes registers between phases and
// reports the verdict from the checker's failure count.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_tracked_object_table_evict_core;
  import tote_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int fail_count, pending;
  int cycle_count = 0;
  int gap_left = 0;
  logic [29:0] id_pool[24];
  logic [31:0] clock_ms = 0;

  always #10 clk = ~clk;

  tracked_object_table_evict_core u_dut (.*);

  tote_checker u_check (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("tb_tracked_object_table_evict_core failed");
      $finish;
    end
  end

  // The result side stalls at random, with calm periods every so often.
  always @(negedge clk) begin
    if (cycle_count % 4096 < 512) out_tready <= 1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_beat(logic [1:0] kind, logic [29:0] id, logic signed [27:0] lat,
                           logic signed [28:0] lon, bit hs, logic [9:0] len,
                           logic [7:0] typ, logic [31:0] now);
    logic [IN_DATA_W-1:0] d;
    if (gap_left == 0 && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 30)) @(negedge clk);
      gap_left = $urandom_range(1, 20);
    end
    if (gap_left > 0) gap_left--;
    d = '0;
    d[IN_MMSI_LO +: 30] = id;
    d[IN_LAT_LO +: 28] = lat;
    d[IN_LON_LO +: 29] = lon;
    d[IN_HSTAT_LO] = hs;
    d[IN_LEN_LO +: 10] = len;
    d[IN_TYPE_LO +: 8] = typ;
    d[IN_NOW_LO +: 32] = now;
    in_tdata <= d;
    in_tuser <= kind;
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid <= 0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic random_beat();
    int r;
    logic [29:0] id;
    logic signed [27:0] lat;
    logic signed [28:0] lon;
    logic [7:0] typ;
    r = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) == 0) ? 30'($urandom_range(0, 999999999))
                                     : id_pool[$urandom_range(0, 23)];
    if ($urandom_range(0, 30) == 0) id = 0;
    lat = 28'($urandom_range(0, 180000000) - 90000000);
    lon = 29'($urandom_range(0, 360000000) - 180000000);
    if ($urandom_range(0, 20) == 0) lat = 28'(32'h0800_0000 + $urandom_range(0, 3));
    if ($urandom_range(0, 20) == 0) lon = 29'(32'h0FFF_FFFF - $urandom_range(0, 3));
    typ = $urandom_range(0, 3) == 0 ? 8'(36 + $urandom_range(0, 1)) : 8'($urandom);
    clock_ms += $urandom_range(0, 40000);
    send_beat(r < 70 ? KIND_POS : r < 88 ? KIND_STATIC : r < 98 ? KIND_EXPIRE : KIND_NONE,
              id, lat, lon, 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)), typ,
              clock_ms);
  endtask

  initial begin
    for (int i = 0; i < 24; i++) id_pool[i] = 30'($urandom_range(1, 999999999));
    id_pool[0] = 30'h3FFFFFFF;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // Directed: zero identifiers, unknown kind, empty and partial static data.
    send_beat(KIND_POS, 0, 0, 0, 1, 5, 5, 0);
    send_beat(KIND_STATIC, 0, 0, 0, 0, 5, 5, 0);
    send_beat(KIND_NONE, 7, 0, 0, 0, 0, 0, 0);
    send_beat(KIND_STATIC, 7, 0, 0, 0, 0, 0, 0);
    send_beat(KIND_STATIC, 7, 0, 0, 0, 10'd1023, 0, 0);
    send_beat(KIND_STATIC, 8, 0, 0, 0, 0, 8'd255, 0);
    send_beat(KIND_POS, 7, 28'sd90000000, -29'sd180000000, 0, 0, 0, 100);
    send_beat(KIND_POS, 8, -28'sd90000000, 29'sd180000000, 1, 10'd1023, 8'd36, 200);
    for (int i = 0; i < 16; i++)
      send_beat(KIND_POS, 30'(100 + i), 28'(i * 1000000), 29'(-i * 2000000), 1,
                10'(i), 8'(i == 3 ? 37 : 70), 32'hFFFF_FFF0 + i);
    send_beat(KIND_EXPIRE, 0, 0, 0, 0, 0, 0, 32'd400000);
    wait_drained();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_CENTRE_LAT, 32'(-90000000));
          write_reg(REG_CENTRE_LON, 32'(180000000));
          write_reg(REG_LON_SCALE, 32'd65535);
          write_reg(REG_LAT_SCALE, 32'd65535);
          write_reg(REG_TTL_MS, 32'hFFFF_FFFF);
          write_reg(REG_MIN_LEN, 32'd1023);
        end
        1: begin
          write_reg(REG_CENTRE_LAT, 32'd90000000);
          write_reg(REG_CENTRE_LON, 32'(-180000000));
          write_reg(REG_LON_SCALE, 32'd0);
          write_reg(REG_LAT_SCALE, 32'd0);
          write_reg(REG_TTL_MS, 32'd1);
          write_reg(REG_MIN_LEN, 32'd0);
        end
        default: begin
          write_reg(REG_CENTRE_LAT, 32'($urandom_range(0, 180000000) - 90000000));
          write_reg(REG_CENTRE_LON, 32'($urandom_range(0, 360000000) - 180000000));
          write_reg(REG_LON_SCALE, $urandom_range(0, 65535));
          write_reg(REG_LAT_SCALE, $urandom_range(0, 65535));
          write_reg(REG_TTL_MS, $urandom_range(50000, 900000));
          write_reg(REG_MIN_LEN, $urandom_range(0, 300));
        end
      endcase
      repeat (200) random_beat();
      wait_drained();
    end
    if (fail_count == 0) begin
      $display("tb_tracked_object_table_evict_core passed");
    end else begin
      $display("tb_tracked_object_table_evict_core failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/tote_pkg.sv
src/tote_ctrl.sv
src/tote_dpath.sv
src/tracked_object_table_evict_core.sv
sim/tote_checker.sv
sim/tb_tracked_object_table_evict_core.sv
